/* rtl/urbs_pkg.sv */
// shared types, constants and scaling factors for the ultrasonic range band sequencer
package urbs_pkg;

    localparam int TICKS_PER_COUNT = 4;
    localparam int COUNT_BITS      = 14;
    localparam int PRESCALE_W      = (TICKS_PER_COUNT > 1) ? $clog2(TICKS_PER_COUNT) : 1;

    localparam int TRIG_W     = 8;
    localparam int PAUSE_W    = 17;
    localparam int DIST_W     = 14;
    localparam int BAND_W     = 3;
    localparam int LED_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [DIST_W-1:0]     DIST_MAX  = '1;

    // distance = floor(SCALE * count / 1000) = floor(floor(SCALE * count / 8) / 125)
    localparam int SCALE    = 170 * TICKS_PER_COUNT;
    localparam int SCALE_W  = 10;
    localparam int X_W      = COUNT_BITS + SCALE_W;
    localparam int Y_W      = X_W - 3;
    localparam int RECIP_S  = Y_W + 7;
    localparam longint unsigned RECIP_M = ((64'd1 << RECIP_S) + 64'd124) / 64'd125;
    localparam int RECIP_W  = RECIP_S - 6;
    localparam int PROD_W   = Y_W + RECIP_W;
    localparam int Q_W      = PROD_W - RECIP_S;
    localparam int CMP_W    = (Q_W > DIST_W) ? Q_W : DIST_W;

    typedef enum logic [2:0] {
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT,
        PH_MEASURE,
        PH_PAUSE
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_WIDTH,
        CFG_PAUSE,
        CFG_THRESH_A,
        CFG_THRESH_B,
        CFG_THRESH_C,
        CFG_THRESH_D,
        CFG_THRESH_E
    } cfg_idx_t;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_width;
        logic [PAUSE_W-1:0] pause;
        logic [DIST_W-1:0]  thresh_a;
        logic [DIST_W-1:0]  thresh_b;
        logic [DIST_W-1:0]  thresh_c;
        logic [DIST_W-1:0]  thresh_d;
        logic [DIST_W-1:0]  thresh_e;
    } cfg_t;

    typedef struct packed {
        logic                  trigger;
        logic                  done;
        logic [COUNT_BITS-1:0] count;
    } ctl_item_t;

    typedef struct packed {
        logic              trigger;
        logic              done;
        logic [DIST_W-1:0] distance;
    } dist_item_t;

    typedef struct packed {
        logic              trigger;
        logic              done;
        logic [DIST_W-1:0] distance;
        logic [BAND_W-1:0] band;
        logic [LED_W-1:0]  led;
    } result_t;

endpackage

/* rtl/urbs_ctrl.sv */
// input register and trigger / echo sequencing state machine
module urbs_ctrl
    import urbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    input  logic      in_echo,
    output logic      in_ready,
    output logic      out_valid,
    output ctl_item_t out_item,
    input  logic      out_ready
);

    logic                  in_valid_reg;
    logic                  echo_reg;
    logic                  out_valid_reg;
    ctl_item_t             item_reg;
    ctl_item_t             item_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [PAUSE_W-1:0]    phase_timer_reg;
    logic [PAUSE_W-1:0]    phase_timer_next;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [PRESCALE_W-1:0] prescale_next;
    logic [COUNT_BITS-1:0] echo_count_reg;
    logic [COUNT_BITS-1:0] echo_count_next;

    logic                  advance;
    logic [PAUSE_W-1:0]    timer_inc;
    logic [TRIG_W-1:0]     width_eff;
    logic [PRESCALE_W-1:0] pre_base;
    logic [COUNT_BITS-1:0] cnt_base;
    logic [PRESCALE_W:0]   pre_sum;
    logic [PRESCALE_W-1:0] tick_pre;
    logic [COUNT_BITS-1:0] tick_cnt;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    // one prescaled echo tick, restarted from zero on the first echo tick
    always_comb
    begin
        pre_base = (phase_reg == PH_WAIT) ? '0 : prescale_reg;
        cnt_base = (phase_reg == PH_WAIT) ? '0 : echo_count_reg;
        pre_sum  = {1'b0, pre_base} + (PRESCALE_W+1)'(1);
        if (pre_sum >= (PRESCALE_W+1)'(TICKS_PER_COUNT))
        begin
            tick_pre = '0;
            tick_cnt = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + COUNT_BITS'(1);
        end
        else
        begin
            tick_pre = pre_sum[PRESCALE_W-1:0];
            tick_cnt = cnt_base;
        end
    end

    always_comb
    begin
        timer_inc        = phase_timer_reg + PAUSE_W'(1);
        width_eff        = (cfg.trigger_width == '0) ? TRIG_W'(1) : cfg.trigger_width;
        phase_next       = phase_reg;
        phase_timer_next = phase_timer_reg;
        prescale_next    = prescale_reg;
        echo_count_next  = echo_count_reg;
        item_next.trigger = 1'b0;
        item_next.done    = 1'b0;
        item_next.count   = echo_count_reg;
        case (phase_reg)
            PH_TRIG_LOW, PH_TRIG_HIGH:
            begin
                item_next.trigger = (phase_reg == PH_TRIG_HIGH);
                phase_timer_next  = timer_inc;
                if (timer_inc >= PAUSE_W'(width_eff))
                begin
                    phase_timer_next = '0;
                    phase_next = (phase_reg == PH_TRIG_LOW) ? PH_TRIG_HIGH : PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (echo_reg)
                begin
                    prescale_next   = tick_pre;
                    echo_count_next = tick_cnt;
                    phase_next      = PH_MEASURE;
                end
            end
            PH_MEASURE:
            begin
                if (echo_reg)
                begin
                    prescale_next   = tick_pre;
                    echo_count_next = tick_cnt;
                end
                else
                begin
                    item_next.done   = 1'b1;
                    phase_timer_next = '0;
                    phase_next       = (cfg.pause == '0) ? PH_TRIG_LOW : PH_PAUSE;
                end
            end
            PH_PAUSE:
            begin
                phase_timer_next = timer_inc;
                if (timer_inc >= cfg.pause)
                begin
                    phase_timer_next = '0;
                    phase_next       = PH_TRIG_LOW;
                end
            end
            default:
            begin
                phase_next       = PH_TRIG_LOW;
                phase_timer_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_TRIG_LOW;
            phase_timer_reg <= '0;
            prescale_reg    <= '0;
            echo_count_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= advance;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                phase_timer_reg <= phase_timer_next;
                prescale_reg    <= prescale_next;
                echo_count_reg  <= echo_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            echo_reg <= in_echo;
        end
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/urbs_dist.sv */
// count to millimeter conversion: scale multiply, reciprocal multiply, saturation
module urbs_dist
    import urbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  ctl_item_t  in_item,
    output logic       in_ready,
    output logic       out_valid,
    output dist_item_t out_item,
    input  logic       out_ready
);

    logic              x_valid_reg;
    logic              x_trigger_reg;
    logic              x_done_reg;
    logic [Y_W-1:0]    y_reg;
    logic              d_valid_reg;
    dist_item_t        d_item_reg;

    logic              x_ready;
    logic              d_ready;
    logic [X_W-1:0]    x_prod;
    logic [PROD_W-1:0] q_prod;
    logic [Q_W-1:0]    q;
    logic [DIST_W-1:0] dist_sat;

    assign d_ready   = !d_valid_reg || out_ready;
    assign x_ready   = !x_valid_reg || d_ready;
    assign in_ready  = x_ready;
    assign out_valid = d_valid_reg;
    assign out_item  = d_item_reg;

    assign x_prod = X_W'(in_item.count) * X_W'(SCALE);
    assign q_prod = PROD_W'(y_reg) * PROD_W'(RECIP_M);
    assign q      = q_prod[PROD_W-1:RECIP_S];

    always_comb
    begin
        if (CMP_W'(q) > CMP_W'(DIST_MAX))
        begin
            dist_sat = DIST_MAX;
        end
        else
        begin
            dist_sat = DIST_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (x_ready)
            begin
                x_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= x_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_ready)
        begin
            x_trigger_reg <= in_item.trigger;
            x_done_reg    <= in_item.done;
            y_reg         <= x_prod[X_W-1:3];
        end
        if (d_ready)
        begin
            d_item_reg.trigger  <= x_trigger_reg;
            d_item_reg.done     <= x_done_reg;
            d_item_reg.distance <= x_done_reg ? dist_sat : '0;
        end
    end

endmodule

/* rtl/urbs_band.sv */
// band compare, led pattern and result register
module urbs_band
    import urbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  dist_item_t in_item,
    output logic       in_ready,
    output logic       out_valid,
    output result_t    out_item,
    input  logic       out_ready
);

    logic              out_valid_reg;
    result_t           result_reg;
    logic [LED_W-1:0]  last_pattern_reg;
    logic [BAND_W-1:0] band;
    logic [LED_W-1:0]  led_new;
    logic              load;

    assign in_ready  = !out_valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = result_reg;

    always_comb
    begin
        if (in_item.distance < cfg.thresh_a)
        begin
            band = BAND_W'(0);
        end
        else if (in_item.distance < cfg.thresh_b)
        begin
            band = BAND_W'(1);
        end
        else if (in_item.distance < cfg.thresh_c)
        begin
            band = BAND_W'(2);
        end
        else if (in_item.distance < cfg.thresh_d)
        begin
            band = BAND_W'(3);
        end
        else if (in_item.distance < cfg.thresh_e)
        begin
            band = BAND_W'(4);
        end
        else
        begin
            band = BAND_W'(5);
        end
        led_new = ~(LED_W'(1) << band);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            last_pattern_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (load && in_item.done)
            begin
                last_pattern_reg <= led_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.trigger  <= in_item.trigger;
            result_reg.done     <= in_item.done;
            result_reg.distance <= in_item.distance;
            result_reg.band     <= in_item.done ? band : '0;
            result_reg.led      <= in_item.done ? led_new : last_pattern_reg;
        end
    end

endmodule

/* rtl/ultrasonic_range_band_sequencer.sv */
// top level of the ultrasonic range band sequencer: config registers and stage chain
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata[0] echo
//  m_axis    out  m_tvalid/m_tready  m_tdata trigger,distance,band,led; m_tuser done
//  cfg       in   cfg_we             cfg_index, cfg_data
//
// one item per cycle while m_tready stays high; each accepted input item gives one result, registered in turn by
// (input reg, sequencer, scale multiply, reciprocal multiply, band/result reg)
// reset loads the register defaults and starts in the trigger low phase
// m_tready low fills the stages; s_tready drops only when all five hold items
module ultrasonic_range_band_sequencer
    import urbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // echo
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // trigger, distance_mm, band, led_pattern
    output logic                  m_tuser,   // done_res
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       ctl_valid;
    logic       ctl_ready;
    ctl_item_t  ctl_item;
    logic       dist_valid;
    logic       dist_ready;
    dist_item_t dist_item;
    result_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width <= TRIG_W'(10);
            cfg_reg.pause         <= PAUSE_W'(100000);
            cfg_reg.thresh_a      <= DIST_W'(30);
            cfg_reg.thresh_b      <= DIST_W'(70);
            cfg_reg.thresh_c      <= DIST_W'(100);
            cfg_reg.thresh_d      <= DIST_W'(130);
            cfg_reg.thresh_e      <= DIST_W'(200);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TRIGGER_WIDTH: cfg_reg.trigger_width <= cfg_data[TRIG_W-1:0];
                CFG_PAUSE:         cfg_reg.pause         <= cfg_data[PAUSE_W-1:0];
                CFG_THRESH_A:      cfg_reg.thresh_a      <= cfg_data[DIST_W-1:0];
                CFG_THRESH_B:      cfg_reg.thresh_b      <= cfg_data[DIST_W-1:0];
                CFG_THRESH_C:      cfg_reg.thresh_c      <= cfg_data[DIST_W-1:0];
                CFG_THRESH_D:      cfg_reg.thresh_d      <= cfg_data[DIST_W-1:0];
                CFG_THRESH_E:      cfg_reg.thresh_e      <= cfg_data[DIST_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    urbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_echo   (s_tdata[0]),
        .in_ready  (s_tready),
        .out_valid (ctl_valid),
        .out_item  (ctl_item),
        .out_ready (ctl_ready)
    );

    urbs_dist u_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ctl_valid),
        .in_item   (ctl_item),
        .in_ready  (ctl_ready),
        .out_valid (dist_valid),
        .out_item  (dist_item),
        .out_ready (dist_ready)
    );

    urbs_band u_band
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (dist_valid),
        .in_item   (dist_item),
        .in_ready  (dist_ready),
        .out_valid (m_tvalid),
        .out_item  (result),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'b0, result.led, result.band, result.distance, result.trigger};
    assign m_tuser = result.done;

endmodule

/* dv/ultrasonic_range_band_sequencer_test.sv */
// self-checking testbench for the ultrasonic range band sequencer: directed table, random echoes
module ultrasonic_range_band_sequencer_test;
    import urbs_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_SLACK  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic                  echo;
        logic [16:0]           reps;
        logic                  known;
        result_t               want;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'd0;   // echo
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;            // trigger, distance_mm, band, led_pattern
    logic                  m_tuser;            // done_res
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic    item_known = 1'b0;
    result_t item_want  = '0;

    logic [TRIG_W-1:0]  trig_width_r = 8'd10;
    logic [PAUSE_W-1:0] pause_r      = 17'd100000;
    logic [DIST_W-1:0]  th_a = 14'd30, th_b = 14'd70, th_c = 14'd100;
    logic [DIST_W-1:0]  th_d = 14'd130, th_e = 14'd200;

    phase_t                rng_phase    = PH_TRIG_LOW;
    logic [PAUSE_W-1:0]    rng_timer    = '0;
    logic [PRESCALE_W-1:0] rng_prescale = '0;
    logic [COUNT_BITS-1:0] rng_count    = '0;
    logic [LED_W-1:0]      rng_led      = '0;

    result_t  pending_results[$];
    dir_row_t dir_rows[$];

    bit          s_fire;
    bit          hold_req;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          stall_cycles;
    int          echo_ticks;
    int          measurements;
    int          settings_used;
    logic [5:0]  bands_seen = '0;
    logic        wave_level = 1'b0;
    int unsigned wave_left;

    ultrasonic_range_band_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function void count_echo_tick();
        if (rng_prescale == PRESCALE_W'(TICKS_PER_COUNT - 1))
        begin
            rng_prescale = '0;
            if (rng_count != COUNT_MAX)
                rng_count = rng_count + 1'b1;
        end
        else
            rng_prescale = rng_prescale + 1'b1;
    endfunction

    function result_t predict_tick(input logic echo_v);
        result_t     r;
        int unsigned span;
        int unsigned d;
        logic [2:0]  b;
        r = '0;
        span = (trig_width_r == 0) ? 1 : trig_width_r;
        case (rng_phase)
            PH_TRIG_LOW, PH_TRIG_HIGH:
            begin
                r.trigger = (rng_phase == PH_TRIG_HIGH);
                rng_timer = rng_timer + 1'b1;
                if (rng_timer >= span)
                begin
                    rng_timer = '0;
                    rng_phase = (rng_phase == PH_TRIG_LOW) ? PH_TRIG_HIGH : PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (echo_v)
                begin
                    rng_prescale = '0;
                    rng_count    = '0;
                    count_echo_tick();
                    rng_phase    = PH_MEASURE;
                end
            end
            PH_MEASURE:
            begin
                if (echo_v)
                    count_echo_tick();
                else
                begin
                    d = (170 * TICKS_PER_COUNT * rng_count) / 1000;
                    if (d > DIST_MAX)
                        d = DIST_MAX;
                    if (d < th_a)      b = 3'd0;
                    else if (d < th_b) b = 3'd1;
                    else if (d < th_c) b = 3'd2;
                    else if (d < th_d) b = 3'd3;
                    else if (d < th_e) b = 3'd4;
                    else               b = 3'd5;
                    rng_led    = ~(LED_W'(1) << b);
                    r.done     = 1'b1;
                    r.distance = DIST_W'(d);
                    r.band     = b;
                    rng_timer  = '0;
                    rng_phase  = (pause_r == 0) ? PH_TRIG_LOW : PH_PAUSE;
                end
            end
            PH_PAUSE:
            begin
                rng_timer = rng_timer + 1'b1;
                if (rng_timer >= pause_r)
                begin
                    rng_timer = '0;
                    rng_phase = PH_TRIG_LOW;
                end
            end
            default:
            begin
                rng_phase = PH_TRIG_LOW;
                rng_timer = '0;
            end
        endcase
        r.led = rng_led;
        return r;
    endfunction

    function void check_field(input string name, input logic [DIST_W-1:0] want_v,
                              input logic [DIST_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endfunction

    always @(negedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        if (!rst_n)
            s_fire = 1'b0;
        else
        begin
            s_fire = s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.trigger  = m_tdata[0];
                got.distance = m_tdata[DIST_W:1];
                got.band     = m_tdata[DIST_W+BAND_W:DIST_W+1];
                got.led      = m_tdata[DIST_W+BAND_W+LED_W:DIST_W+BAND_W+1];
                got.done     = m_tuser;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("trigger", want.trigger, got.trigger);
                    check_field("done_res", want.done, got.done);
                    check_field("distance_mm", want.distance, got.distance);
                    check_field("band", want.band, got.band);
                    check_field("led_pattern", want.led, got.led);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRIGGER_WIDTH: trig_width_r = cfg_data[TRIG_W-1:0];
                    CFG_PAUSE:         pause_r      = cfg_data[PAUSE_W-1:0];
                    CFG_THRESH_A:      th_a         = cfg_data[DIST_W-1:0];
                    CFG_THRESH_B:      th_b         = cfg_data[DIST_W-1:0];
                    CFG_THRESH_C:      th_c         = cfg_data[DIST_W-1:0];
                    CFG_THRESH_D:      th_d         = cfg_data[DIST_W-1:0];
                    CFG_THRESH_E:      th_e         = cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (s_fire)
            begin
                pred = predict_tick(s_tdata[0]);
                pending_results.push_back(item_known ? item_want : pred);
                echo_ticks++;
                if (pred.done)
                begin
                    measurements++;
                    bands_seen[pred.band] = 1'b1;
                end
            end
            if (s_fire || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, pending_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function void add_ticks(input logic echo_v, input int unsigned reps);
        dir_row_t row;
        row      = '0;
        row.echo = echo_v;
        row.reps = 17'(reps);
        dir_rows.push_back(row);
    endfunction

    function void add_known(input logic echo_v, input int unsigned reps, input result_t want);
        dir_row_t row;
        row       = '0;
        row.echo  = echo_v;
        row.reps  = 17'(reps);
        row.known = 1'b1;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row        = '0;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        dir_rows.push_back(row);
    endfunction

    function logic next_echo();
        if ($urandom_range(9) == 0)
            return 1'($urandom_range(1));
        if (wave_left == 0)
        begin
            wave_level = !wave_level;
            if (wave_level)
                wave_left = ($urandom_range(15) == 0) ? $urandom_range(121, 2500)
                                                      : $urandom_range(1, 120);
            else
                wave_left = $urandom_range(1, 30);
        end
        wave_left--;
        return wave_level;
    endfunction

    task automatic send_item(input logic echo_v, input logic known, input result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {7'd0, echo_v};
        item_known <= known;
        item_want  <= want;
        @(posedge clk);
        while (!s_fire)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int min_items,
                             input int min_meas, input bit pressure, input bit extreme);
        int          sent;
        int          first_meas;
        int unsigned th[$];
        drain_pipeline();
        if (extreme)
        begin
            write_reg(CFG_TRIGGER_WIDTH, 17'd255);
            write_reg(CFG_PAUSE, 17'd131071);
            th = '{0, 0, 0, 0, 11140};
        end
        else
        begin
            write_reg(CFG_TRIGGER_WIDTH, ($urandom_range(7) == 0) ? 17'd0 : 17'($urandom_range(1, 4)));
            write_reg(CFG_PAUSE, 17'($urandom_range(0, 12)));
            repeat (5) th.push_back($urandom_range(0, 25));
            if ($urandom_range(3) != 0)
                th.sort();
        end
        write_reg(CFG_THRESH_A, 17'(th[0]));
        write_reg(CFG_THRESH_B, 17'(th[1]));
        write_reg(CFG_THRESH_C, 17'(th[2]));
        write_reg(CFG_THRESH_D, 17'(th[3]));
        write_reg(CFG_THRESH_E, 17'(th[4]));
        settings_used++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first_meas     = measurements;
        sent           = 0;
        while (sent < min_items || measurements - first_meas < min_meas)
        begin
            // long receiver hold-off fills the stages, later the sender waits for a full drain
            if (pressure && sent == 150)
                hold_req = 1'b1;
            if (pressure && sent == 400)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            send_item(next_echo(), 1'b0, '0);
            sent++;
        end
    endtask

    initial
    begin
        // defaults after reset, echo ignored while the trigger runs, then a saturating echo
        add_known(1'b1, 10, '{1'b0, 1'b0, 14'd0, 3'd0, 8'h00});
        add_known(1'b1, 10, '{1'b1, 1'b0, 14'd0, 3'd0, 8'h00});
        add_known(1'b0, 4, '{1'b0, 1'b0, 14'd0, 3'd0, 8'h00});
        add_ticks(1'b1, 65600);
        add_known(1'b0, 1, '{1'b0, 1'b1, 14'd11140, 3'd5, 8'hDF});
        add_known(1'b0, 3, '{1'b0, 1'b0, 14'd0, 3'd0, 8'hDF});
        // zero pause, zero trigger width, unordered thresholds
        add_reg(CFG_PAUSE, 17'd0);
        add_reg(CFG_TRIGGER_WIDTH, 17'd0);
        add_reg(CFG_THRESH_A, 17'd5);
        add_reg(CFG_THRESH_B, 17'd3);
        add_reg(CFG_THRESH_C, 17'd0);
        add_reg(CFG_THRESH_D, 17'd20);
        add_reg(CFG_THRESH_E, 17'd11140);
        add_ticks(1'b1, 6);
        add_ticks(1'b0, 3);
        add_ticks(1'b1, 100);
        add_ticks(1'b0, 3);
        add_ticks(1'b1, 200);
        add_ticks(1'b0, 3);
        // unused index, value masked to the register width, widest trigger
        add_reg(CFG_IDX_SPARE, 17'h1FFFF);
        add_reg(CFG_THRESH_A, 17'h1FFFF);
        add_reg(CFG_TRIGGER_WIDTH, 17'd255);
        add_ticks(1'b0, 520);
        add_ticks(1'b1, 9);
        add_ticks(1'b0, 1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_reg)
            begin
                drain_pipeline();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                repeat (dir_rows[i].reps)
                    send_item(dir_rows[i].echo, dir_rows[i].known, dir_rows[i].want);
        end

        run_phase(0, 0, 500, 8, 1'b1, 1'b0);
        run_phase(52, 0, 375, 8, 1'b0, 1'b0);
        run_phase(0, 52, 375, 8, 1'b0, 1'b0);
        run_phase(30, 30, 375, 8, 1'b0, 1'b0);
        run_phase(0, 0, 0, 2, 1'b0, 1'b1);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d echo ticks, %0d completed measurements, %0d random settings",
                 echo_ticks, measurements, settings_used);
        $display("bands reported (bit per band): %b, mismatches: %0d", bands_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
